### rtl/core/stoc_pkg.sv
// ----------------------------------------------------------------------------
// stoc_pkg
// Shared types and constants for the segment table overlap checker.
// ----------------------------------------------------------------------------
package stoc_pkg;

    localparam int ENTRIES_DEF   = 16;
    localparam int NAME_BITS_DEF = 64;
    localparam int ADDR_BITS_DEF = 32;

    // port widths fixed by the request and result formats
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int SLOT_W      = 4;
    localparam int NAME_PORT_W = 64;
    localparam int ADDR_PORT_W = 32;

    // most results a single list request produces
    localparam int LIST_CAP = 16;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_LIST   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERLAP   = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic overlap;
        logic name_hit;
    } t_cmp_res;

endpackage

### rtl/core/stoc_ram.sv
// ----------------------------------------------------------------------------
// stoc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/stoc_cmp.sv
// ----------------------------------------------------------------------------
// stoc_cmp
// Shared compare unit: region overlap test and name tag match for one entry.
// ----------------------------------------------------------------------------
module stoc_cmp #(
    parameter int NAME_BITS = stoc_pkg::NAME_BITS_DEF,
    parameter int ADDR_BITS = stoc_pkg::ADDR_BITS_DEF
) (
    input  logic [ADDR_BITS-1:0] i_new_start,
    input  logic [ADDR_BITS-1:0] i_new_end,
    input  logic [NAME_BITS-1:0] i_new_name,
    input  logic [ADDR_BITS-1:0] i_ent_start,
    input  logic [ADDR_BITS-1:0] i_ent_end,
    input  logic [NAME_BITS-1:0] i_ent_name,
    output stoc_pkg::t_cmp_res   o_res
);
    import stoc_pkg::*;

    logic w_start_in;
    logic w_end_in;
    logic w_encloses;

    // start in [a,b), end in (a,b], or strictly around the entry
    assign w_start_in = (i_new_start >= i_ent_start) && (i_new_start < i_ent_end);
    assign w_end_in   = (i_new_end > i_ent_start) && (i_new_end <= i_ent_end);
    assign w_encloses = (i_new_start < i_ent_start) && (i_new_end > i_ent_end);

    assign o_res.overlap  = w_start_in || w_end_in || w_encloses;
    assign o_res.name_hit = (i_new_name == i_ent_name);

endmodule

### rtl/core/segment_table_overlap_check.sv
// ----------------------------------------------------------------------------
// segment_table_overlap_check
// Table of named address regions with create, lookup and list requests.
// ----------------------------------------------------------------------------
// A request is taken when i_start is high and o_busy is low. i_op selects
// create (overlap check, then store in the highest free slot), lookup (first
// used slot with a matching name) or list (every used entry in slot order,
// up to LIST_CAP of them). Op code 3 is dropped without a result.
// Results appear on the o_ ports for one cycle with o_valid high; o_last
// marks the final result of a request. The receiver cannot stall, so results
// are never held back.
// The sequencer reads one table entry per cycle from the entry RAM and runs
// it through a single compare unit: a request keeps o_busy high through the
// scan of all ENTRIES slots and the finish state, or ends sooner when a create
// hits an overlap or a lookup finds its name. The final result shows in the
// first cycle with o_busy low, in which the next request can already be taken;
// list results before the last come during the scan.
// Reset (synchronous, active low) clears all used marks, emptying the table;
// entry data is not cleared and is only read behind its used mark.
// ----------------------------------------------------------------------------
module segment_table_overlap_check #(
    parameter int ENTRIES   = stoc_pkg::ENTRIES_DEF,
    parameter int NAME_BITS = stoc_pkg::NAME_BITS_DEF,
    parameter int ADDR_BITS = stoc_pkg::ADDR_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [stoc_pkg::OP_W-1:0]        i_op,
    input  logic [stoc_pkg::NAME_PORT_W-1:0] i_name_tag,
    input  logic [stoc_pkg::ADDR_PORT_W-1:0] i_region_start,
    input  logic [stoc_pkg::ADDR_PORT_W-1:0] i_region_end,
    output logic                             o_valid,
    output logic [stoc_pkg::STATUS_W-1:0]    o_status,
    output logic [stoc_pkg::SLOT_W-1:0]      o_slot_index,
    output logic [stoc_pkg::NAME_PORT_W-1:0] o_entry_name,
    output logic [stoc_pkg::ADDR_PORT_W-1:0] o_entry_start,
    output logic [stoc_pkg::ADDR_PORT_W-1:0] o_entry_end,
    output logic                             o_last
);
    import stoc_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int WORD_W = NAME_BITS + 2 * ADDR_BITS;
    localparam int CNT_W  = $clog2(LIST_CAP + 1);

    t_state               r_state, n_state;
    t_op                  r_op;
    logic [NAME_BITS-1:0] r_name;
    logic [ADDR_BITS-1:0] r_s;
    logic [ADDR_BITS-1:0] r_e;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_rd_on;
    logic                 r_chk_vld;
    logic [IDX_W-1:0]     r_chk_idx;
    logic [ENTRIES-1:0]   r_used;
    logic [IDX_W-1:0]     r_free;
    logic                 r_free_vld;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_pend_vld;
    logic [IDX_W-1:0]     r_pend_idx;
    logic [NAME_BITS-1:0] r_pend_name;
    logic [ADDR_BITS-1:0] r_pend_start;
    logic [ADDR_BITS-1:0] r_pend_end;

    logic                 r_out_vld,   n_out_vld;
    t_status              r_out_status, n_out_status;
    logic [IDX_W-1:0]     r_out_slot,  n_out_slot;
    logic [NAME_BITS-1:0] r_out_name,  n_out_name;
    logic [ADDR_BITS-1:0] r_out_start, n_out_start;
    logic [ADDR_BITS-1:0] r_out_end,   n_out_end;
    logic                 r_out_last,  n_out_last;

    logic                 c_accept;
    logic                 c_rd_en;
    logic                 c_chk;
    logic                 c_hit_stop;
    logic                 c_scan_end;
    logic                 c_take;
    logic                 c_free;
    logic                 c_we;

    logic [WORD_W-1:0]    w_rdata;
    logic [NAME_BITS-1:0] w_ent_name;
    logic [ADDR_BITS-1:0] w_ent_start;
    logic [ADDR_BITS-1:0] w_ent_end;
    logic                 w_chk_used;
    t_cmp_res             w_cmp;

    stoc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (r_free),
        .i_wdata ({r_name, r_s, r_e}),
        .i_re    (c_rd_en),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    assign w_ent_name  = w_rdata[WORD_W-1 -: NAME_BITS];
    assign w_ent_start = w_rdata[2*ADDR_BITS-1 -: ADDR_BITS];
    assign w_ent_end   = w_rdata[ADDR_BITS-1:0];
    assign w_chk_used  = r_used[r_chk_idx];

    stoc_cmp #(
        .NAME_BITS (NAME_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_cmp (
        .i_new_start (r_s),
        .i_new_end   (r_e),
        .i_new_name  (r_name),
        .i_ent_start (w_ent_start),
        .i_ent_end   (w_ent_end),
        .i_ent_name  (w_ent_name),
        .o_res       (w_cmp)
    );

    // sequencer control decode
    always_comb begin
        c_accept   = i_start && (r_state == S_IDLE);
        c_rd_en    = (r_state == S_SCAN) && r_rd_on;
        c_chk      = (r_state == S_SCAN) && r_chk_vld;
        c_hit_stop = c_chk && w_chk_used &&
                     (((r_op == OP_CREATE) && w_cmp.overlap) ||
                      ((r_op == OP_LOOKUP) && w_cmp.name_hit));
        c_scan_end = c_chk && (r_chk_idx == IDX_W'(ENTRIES - 1)) && !c_hit_stop;
        c_take     = c_chk && w_chk_used && (r_op == OP_LIST) &&
                     (r_cnt < CNT_W'(LIST_CAP));
        c_free     = c_chk && !w_chk_used && (r_op == OP_CREATE);
        c_we       = (r_state == S_FINISH) && (r_op == OP_CREATE) && r_free_vld;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (c_accept && (t_op'(i_op) != OP_NONE)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (c_hit_stop) begin
                    n_state = S_IDLE;
                end else if (c_scan_end) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // result selection
    always_comb begin
        n_out_vld    = 1'b0;
        n_out_status = STAT_OK;
        n_out_slot   = '0;
        n_out_name   = '0;
        n_out_start  = '0;
        n_out_end    = '0;
        n_out_last   = 1'b1;
        case (r_state)
            S_SCAN: begin
                if (c_hit_stop) begin
                    n_out_vld = 1'b1;
                    if (r_op == OP_CREATE) begin
                        n_out_status = STAT_OVERLAP;
                    end else begin
                        n_out_slot = r_chk_idx;
                    end
                end else if (c_take && r_pend_vld) begin
                    // a newer entry exists, so the held one is not the last
                    n_out_vld   = 1'b1;
                    n_out_slot  = r_pend_idx;
                    n_out_name  = r_pend_name;
                    n_out_start = r_pend_start;
                    n_out_end   = r_pend_end;
                    n_out_last  = 1'b0;
                end
            end
            S_FINISH: begin
                n_out_vld = 1'b1;
                case (r_op)
                    OP_CREATE: begin
                        if (r_free_vld) begin
                            n_out_slot = r_free;
                        end else begin
                            n_out_status = STAT_FULL;
                        end
                    end
                    OP_LIST: begin
                        if (r_pend_vld) begin
                            n_out_slot  = r_pend_idx;
                            n_out_name  = r_pend_name;
                            n_out_start = r_pend_start;
                            n_out_end   = r_pend_end;
                        end else begin
                            n_out_status = STAT_NOT_FOUND;
                        end
                    end
                    default: n_out_status = STAT_NOT_FOUND;
                endcase
            end
            default: n_out_vld = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rd_on    <= 1'b0;
            r_chk_vld  <= 1'b0;
            r_used     <= '0;
            r_free_vld <= 1'b0;
            r_pend_vld <= 1'b0;
            r_cnt      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (c_accept) begin
                r_rd_on    <= 1'b1;
                r_chk_vld  <= 1'b0;
                r_free_vld <= 1'b0;
                r_pend_vld <= 1'b0;
                r_cnt      <= '0;
            end else begin
                if (c_rd_en && (r_idx == IDX_W'(ENTRIES - 1))) begin
                    r_rd_on <= 1'b0;
                end
                r_chk_vld <= c_rd_en;
                if (c_free) begin
                    r_free_vld <= 1'b1;
                end
                if (c_take) begin
                    r_pend_vld <= 1'b1;
                    r_cnt      <= r_cnt + CNT_W'(1);
                end
                if (c_we) begin
                    r_used[r_free] <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_op   <= t_op'(i_op);
            r_name <= NAME_BITS'(i_name_tag);
            r_s    <= ADDR_BITS'(i_region_start);
            r_e    <= ADDR_BITS'(i_region_end);
            r_idx  <= '0;
        end else if (c_rd_en) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        r_chk_idx <= r_idx;
        // highest free slot wins since the scan runs upward
        if (c_free) begin
            r_free <= r_chk_idx;
        end
        if (c_take) begin
            r_pend_idx   <= r_chk_idx;
            r_pend_name  <= w_ent_name;
            r_pend_start <= w_ent_start;
            r_pend_end   <= w_ent_end;
        end
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_name   <= n_out_name;
        r_out_start  <= n_out_start;
        r_out_end    <= n_out_end;
        r_out_last   <= n_out_last;
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_valid       = r_out_vld;
    assign o_status      = r_out_status;
    assign o_slot_index  = SLOT_W'(r_out_slot);
    assign o_entry_name  = NAME_PORT_W'(r_out_name);
    assign o_entry_start = ADDR_PORT_W'(r_out_start);
    assign o_entry_end   = ADDR_PORT_W'(r_out_end);
    assign o_last        = r_out_last;

`ifndef NO_ASSERTIONS
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy))
        else $error("result without an active request");

    a_last_ends_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !o_busy)
        else $error("final result while sequencer still busy");

    a_mid_list_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> o_busy)
        else $error("non-final result after sequencer finished");

    a_write_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_we |-> !r_used[r_free])
        else $error("create overwrites a used slot");

    a_bad_op_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_accept && (i_op == OP_NONE)) |=> (!o_busy && !o_valid))
        else $error("unused op code started a scan");
`endif

endmodule

### tb/segment_table_overlap_check_checker.sv
// ----------------------------------------------------------------------------
// segment_table_overlap_check_checker
// Watches the request and result ports of the region table, keeps its own
// copy of the table, predicts the results of every accepted request and
// compares each result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module segment_table_overlap_check_checker
    import stoc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_busy,
    input  logic [OP_W-1:0]        i_op,
    input  logic [NAME_PORT_W-1:0] i_name_tag,
    input  logic [ADDR_PORT_W-1:0] i_region_start,
    input  logic [ADDR_PORT_W-1:0] i_region_end,
    input  logic                   i_valid,
    input  logic [STATUS_W-1:0]    i_status,
    input  logic [SLOT_W-1:0]      i_slot_index,
    input  logic [NAME_PORT_W-1:0] i_entry_name,
    input  logic [ADDR_PORT_W-1:0] i_entry_start,
    input  logic [ADDR_PORT_W-1:0] i_entry_end,
    input  logic                   i_last,
    output int                     o_mismatches,
    output int                     o_pending
);

    localparam int MAX_REPORTS = 10;

    typedef struct {
        t_status                status;
        logic [SLOT_W-1:0]      slot;
        logic [NAME_PORT_W-1:0] name;
        logic [ADDR_PORT_W-1:0] base;
        logic [ADDR_PORT_W-1:0] limit;
        logic                   last;
    } region_result_t;

    logic                   table_used  [ENTRIES_DEF];
    logic [NAME_PORT_W-1:0] table_name  [ENTRIES_DEF];
    logic [ADDR_PORT_W-1:0] table_base  [ENTRIES_DEF];
    logic [ADDR_PORT_W-1:0] table_limit [ENTRIES_DEF];

    region_result_t expected_results [$];
    int             mismatch_count = 0;

    // half-open regions, unsigned compares, no sanity check on start <= end
    function automatic logic regions_collide(logic [ADDR_PORT_W-1:0] s, e, a, b);
        return (s >= a && s < b) || (e > a && e <= b) || (s < a && e > b);
    endfunction

    function automatic region_result_t status_only(t_status st, logic [SLOT_W-1:0] slot);
        region_result_t r;
        r.status = st;
        r.slot   = slot;
        r.name   = '0;
        r.base   = '0;
        r.limit  = '0;
        r.last   = 1'b1;
        return r;
    endfunction

    task automatic apply_table_request(t_op op, logic [NAME_PORT_W-1:0] nm,
                                       logic [ADDR_PORT_W-1:0] s, e);
        int             free_slot;
        int             collisions;
        int             found;
        int             listed;
        int             total;
        region_result_t r;
        free_slot  = -1;
        collisions = 0;
        found      = -1;
        listed     = 0;
        total      = 0;
        case (op)
            OP_CREATE: begin
                for (int i = 0; i < ENTRIES_DEF; i++) begin
                    if (!table_used[i])
                        free_slot = i;
                    else if (regions_collide(s, e, table_base[i], table_limit[i]))
                        collisions++;
                end
                if (collisions != 0) begin
                    expected_results.push_back(status_only(STAT_OVERLAP, '0));
                end else if (free_slot < 0) begin
                    expected_results.push_back(status_only(STAT_FULL, '0));
                end else begin
                    table_used[free_slot]  = 1'b1;
                    table_name[free_slot]  = nm;
                    table_base[free_slot]  = s;
                    table_limit[free_slot] = e;
                    expected_results.push_back(status_only(STAT_OK, SLOT_W'(free_slot)));
                end
            end
            OP_LOOKUP: begin
                for (int i = 0; i < ENTRIES_DEF; i++)
                    if (found < 0 && table_used[i] && table_name[i] == nm)
                        found = i;
                if (found < 0)
                    expected_results.push_back(status_only(STAT_NOT_FOUND, '0));
                else
                    expected_results.push_back(status_only(STAT_OK, SLOT_W'(found)));
            end
            OP_LIST: begin
                for (int i = 0; i < ENTRIES_DEF; i++)
                    if (table_used[i])
                        total++;
                if (total > LIST_CAP)
                    total = LIST_CAP;
                if (total == 0)
                    expected_results.push_back(status_only(STAT_NOT_FOUND, '0));
                for (int i = 0; i < ENTRIES_DEF; i++) begin
                    if (table_used[i] && listed < total) begin
                        listed++;
                        r.status = STAT_OK;
                        r.slot   = SLOT_W'(i);
                        r.name   = table_name[i];
                        r.base   = table_base[i];
                        r.limit  = table_limit[i];
                        r.last   = (listed == total);
                        expected_results.push_back(r);
                    end
                end
            end
            default: begin
                // unused op code, dropped by the block
            end
        endcase
    endtask

    // results are compared before the request of the same edge is predicted:
    // a request cannot produce a result at the edge that accepts it
    always @(posedge i_clk) begin : watch
        region_result_t got;
        region_result_t want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES_DEF; i++)
                table_used[i] = 1'b0;
            expected_results.delete();
        end else begin
            if (i_valid) begin
                got.status = t_status'(i_status);
                got.slot   = i_slot_index;
                got.name   = i_entry_name;
                got.base   = i_entry_start;
                got.limit  = i_entry_end;
                got.last   = i_last;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: result with nothing expected: st=%0d slot=%0d last=%b",
                                 $realtime, got.status, got.slot, got.last);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.slot !== want.slot ||
                        got.name !== want.name || got.base !== want.base ||
                        got.limit !== want.limit || got.last !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("%0t: mismatch exp st=%0d slot=%0d name=%h start=%h end=%h last=%b",
                                     $realtime, want.status, want.slot, want.name,
                                     want.base, want.limit, want.last);
                            $display("%0t:          got st=%0d slot=%0d name=%h start=%h end=%h last=%b",
                                     $realtime, got.status, got.slot, got.name,
                                     got.base, got.limit, got.last);
                        end
                    end
                end
            end
            if (i_start && !i_busy)
                apply_table_request(t_op'(i_op), i_name_tag, i_region_start, i_region_end);
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_results.size();
    end

endmodule

### tb/segment_table_overlap_check_tb.sv
// ----------------------------------------------------------------------------
// segment_table_overlap_check_tb
// Drives create, lookup and list requests into the region table: a directed
// sweep of overlap corners and table edge cases, then random traffic in
// phases with different amounts of sender idling. Checking is done by the
// checker instance beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module segment_table_overlap_check_tb;
    import stoc_pkg::*;

    localparam int RANDOM_REQUESTS = 100;
    localparam int SETTLE_CYCLES   = ENTRIES_DEF + 6;
    localparam int LIMIT_CYCLES    = 200000;

    localparam logic [63:0] NAME_TEXT  = 64'h0000_0074_6578_7421;
    localparam logic [63:0] NAME_HEAP  = 64'h0000_0068_6561_7021;
    localparam logic [63:0] NAME_WRAP  = 64'h5555_AAAA_5555_AAAA;
    localparam logic [63:0] NAME_ALL1  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NAME_ZERO  = 64'h0;

    logic clk = 1'b0;
    logic rst_n;

    logic                   req_start;
    logic                   busy;
    logic [OP_W-1:0]        req_op;
    logic [NAME_PORT_W-1:0] req_name;
    logic [ADDR_PORT_W-1:0] req_base;
    logic [ADDR_PORT_W-1:0] req_limit;

    logic                   rsp_valid;
    logic [STATUS_W-1:0]    rsp_status;
    logic [SLOT_W-1:0]      rsp_slot;
    logic [NAME_PORT_W-1:0] rsp_name;
    logic [ADDR_PORT_W-1:0] rsp_base;
    logic [ADDR_PORT_W-1:0] rsp_limit;
    logic                   rsp_last;

    int mismatches;
    int pending;
    int cycle_count = 0;
    int sender_idle_pct;
    int idle_by_phase [4] = '{0, 67, 0, 9};

    logic [ADDR_PORT_W-1:0] fresh_base = 32'h1000_0000;
    logic [NAME_PORT_W-1:0] sent_names [$];
    logic [ADDR_PORT_W-1:0] sent_bases [$];
    logic [ADDR_PORT_W-1:0] sent_limits [$];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    segment_table_overlap_check u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (req_start),
        .o_busy         (busy),
        .i_op           (req_op),
        .i_name_tag     (req_name),
        .i_region_start (req_base),
        .i_region_end   (req_limit),
        .o_valid        (rsp_valid),
        .o_status       (rsp_status),
        .o_slot_index   (rsp_slot),
        .o_entry_name   (rsp_name),
        .o_entry_start  (rsp_base),
        .o_entry_end    (rsp_limit),
        .o_last         (rsp_last)
    );

    segment_table_overlap_check_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (req_start),
        .i_busy         (busy),
        .i_op           (req_op),
        .i_name_tag     (req_name),
        .i_region_start (req_base),
        .i_region_end   (req_limit),
        .i_valid        (rsp_valid),
        .i_status       (rsp_status),
        .i_slot_index   (rsp_slot),
        .i_entry_name   (rsp_name),
        .i_entry_start  (rsp_base),
        .i_entry_end    (rsp_limit),
        .i_last         (rsp_last),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // leaves start high on return; the next request or a gap takes it from there
    task automatic issue_request(t_op op, logic [NAME_PORT_W-1:0] nm,
                                 logic [ADDR_PORT_W-1:0] s, e);
        req_op    <= op;
        req_name  <= nm;
        req_base  <= s;
        req_limit <= e;
        req_start <= 1'b1;
        if (op == OP_CREATE) begin
            sent_names.push_back(nm);
            sent_bases.push_back(s);
            sent_limits.push_back(e);
        end
        do @(posedge clk); while (busy);
    endtask

    // idle gap with junk on the request fields, taken in sender_idle_pct percent of calls
    task automatic sender_gap();
        if ($urandom_range(99) < sender_idle_pct) begin
            req_start <= 1'b0;
            req_op    <= OP_W'($urandom_range(3));
            req_name  <= {$urandom, $urandom};
            req_base  <= $urandom;
            req_limit <= $urandom;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        req_start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_create();
        logic [NAME_PORT_W-1:0] nm;
        logic [ADDR_PORT_W-1:0] s;
        logic [ADDR_PORT_W-1:0] e;
        logic [ADDR_PORT_W-1:0] a;
        logic [ADDR_PORT_W-1:0] b;
        int                     kind;
        int                     pick;
        kind = $urandom_range(99);
        nm   = {$urandom, $urandom};
        if ($urandom_range(9) == 0)
            nm = sent_names[$urandom_range(sent_names.size() - 1)];
        pick = $urandom_range(sent_bases.size() - 1);
        a    = sent_bases[pick];
        b    = sent_limits[pick];
        if (kind < 35) begin
            // fresh region above the fresh regions placed so far
            s = fresh_base;
            e = s + $urandom_range(1, 32'hFFFF);
            fresh_base = fresh_base + 32'h0002_0000;
        end else if (kind < 85) begin
            case ($urandom_range(4))
                0: begin
                    s = a + $urandom_range(0, 15);
                    e = s + $urandom_range(1, 32'h1000);
                end
                1: begin
                    e = a + $urandom_range(1, 16);
                    s = e - $urandom_range(1, 32'h1000);
                end
                2: begin
                    s = a - $urandom_range(1, 16);
                    e = b + $urandom_range(1, 16);
                end
                3: begin
                    s = b;
                    e = b + 32'h100;
                end
                default: begin
                    e = a;
                    s = a - 32'h100;
                end
            endcase
        end else begin
            s = $urandom;
            e = $urandom;
        end
        issue_request(OP_CREATE, nm, s, e);
    endtask

    initial begin
        int kind;
        int done_count;
        logic [NAME_PORT_W-1:0] nm;

        rst_n     <= 1'b0;
        req_start <= 1'b0;
        req_op    <= OP_NONE;
        req_name  <= '0;
        req_base  <= '0;
        req_limit <= '0;
        sender_idle_pct = 50;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table
        issue_request(OP_LIST, NAME_ZERO, '0, '0);               sender_gap();
        issue_request(OP_LOOKUP, NAME_ZERO, '0, '0);             sender_gap();
        issue_request(OP_CREATE, NAME_TEXT, 32'h1000, 32'h2000); sender_gap();
        // inverted and empty regions are stored as given
        issue_request(OP_CREATE, NAME_HEAP, 32'h30, 32'h20);     sender_gap();
        issue_request(OP_CREATE, NAME_HEAP, 32'h800, 32'h800);   sender_gap();
        // start inside, end inside, enclosing
        issue_request(OP_CREATE, NAME_WRAP, 32'h1800, 32'h2800); sender_gap();
        issue_request(OP_CREATE, NAME_WRAP, 32'h0F00, 32'h1100); sender_gap();
        issue_request(OP_CREATE, NAME_WRAP, 32'h0900, 32'h3000); sender_gap();
        // touching the end of an entry is not an overlap
        issue_request(OP_CREATE, NAME_WRAP, 32'h2000, 32'h3000); sender_gap();
        issue_request(OP_CREATE, NAME_ALL1, 32'hFFFF_FF00, 32'hFFFF_FFFF); sender_gap();
        issue_request(OP_CREATE, NAME_ZERO, 32'h0, 32'h10);      sender_gap();
        // duplicate name, lookup must report the lowest slot
        issue_request(OP_CREATE, NAME_TEXT, 32'h4000, 32'h5000); sender_gap();
        issue_request(OP_LOOKUP, NAME_TEXT, $urandom, $urandom); sender_gap();
        issue_request(OP_LOOKUP, NAME_ALL1, '0, '0);             sender_gap();
        issue_request(OP_LOOKUP, NAME_ZERO, '1, '1);             sender_gap();
        issue_request(OP_LOOKUP, 64'h0123_4567_89AB_CDEF, '0, '0); sender_gap();
        issue_request(OP_NONE, NAME_TEXT, 32'h1000, 32'h2000);   sender_gap();
        issue_request(OP_LIST, NAME_ALL1, '1, '1);               sender_gap();
        issue_request(OP_CREATE, NAME_WRAP, 32'hFFFF_FFFF, 32'h0); sender_gap();
        issue_request(OP_LIST, NAME_ZERO, '0, '0);
        drain_results();

        done_count = 0;
        while (done_count < RANDOM_REQUESTS) begin
            if (done_count % (RANDOM_REQUESTS / 4 + 1) == 0) begin
                sender_idle_pct = idle_by_phase[done_count / (RANDOM_REQUESTS / 4 + 1)];
                if (done_count != 0)
                    drain_results();
            end
            kind = $urandom_range(99);
            if (kind < 40) begin
                random_create();
                done_count++;
            end else if (kind < 70) begin
                nm = {$urandom, $urandom};
                if ($urandom_range(9) < 6)
                    nm = sent_names[$urandom_range(sent_names.size() - 1)];
                issue_request(OP_LOOKUP, nm, $urandom, $urandom);
                done_count++;
            end else if (kind < 92) begin
                issue_request(OP_LIST, {$urandom, $urandom}, $urandom, $urandom);
                done_count++;
            end else begin
                issue_request(OP_NONE, {$urandom, $urandom}, $urandom, $urandom);
            end
            sender_gap();
        end
        drain_results();

        if (mismatches == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
rtl/core/stoc_pkg.sv
rtl/core/stoc_ram.sv
rtl/core/stoc_cmp.sv
rtl/core/segment_table_overlap_check.sv
tb/segment_table_overlap_check_checker.sv
tb/segment_table_overlap_check_tb.sv
